// ===== rtl/dgspl_pkg.sv =====
// ----------------------------------------------------------------------------
// dgspl_pkg
// Shared types, register indexes and constants of the dark-gated sonar lamp.
// ----------------------------------------------------------------------------
package dgspl_pkg;

    localparam int LIGHT_BITS = 12;
    localparam int WIDTH_BITS = 16;
    localparam int TICK_BITS  = 22;
    localparam int DIST_BITS  = 11;
    localparam int TRIG_BITS  = 8;
    localparam int TOUT_BITS  = 16;
    localparam int PROD_BITS  = WIDTH_BITS + DIST_BITS;

    // distance = width * 1114 >> 16, fixed-point form of width * 0.017
    localparam int DIST_SCALE = 1114;
    localparam int DIST_SHIFT = 16;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 22;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DARK_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_TICKS  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RISE_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FALL_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TICKS     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_TICKS   = 3'd6;

    localparam logic [LIGHT_BITS-1:0] RST_DARK_THRESHOLD = 12'd3000;
    localparam logic [TRIG_BITS-1:0]  RST_TRIGGER_TICKS  = 8'd10;
    localparam logic [TOUT_BITS-1:0]  RST_RISE_TIMEOUT   = 16'd10000;
    localparam logic [TOUT_BITS-1:0]  RST_FALL_TIMEOUT   = 16'd50000;
    localparam logic [DIST_BITS-1:0]  RST_NEAR_LIMIT     = 11'd20;
    localparam logic [TICK_BITS-1:0]  RST_HOLD_TICKS     = 22'd3000000;
    localparam logic [TICK_BITS-1:0]  RST_PERIOD_TICKS   = 22'd100000;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_TRIG   = 3'd1,
        PH_RISE   = 3'd2,
        PH_FALL   = 3'd3,
        PH_HOLD   = 3'd4,
        PH_PERIOD = 3'd5
    } phase_t;

    typedef struct packed {
        logic                  echo_level;
        logic                  light_valid;
        logic [LIGHT_BITS-1:0] light_sample;
    } in_item_t;

    typedef struct packed {
        logic                 trigger_out;
        logic                 lamp_on;
        logic [DIST_BITS-1:0] distance_cm;
        logic                 distance_done;
    } out_item_t;

    typedef struct packed {
        logic [LIGHT_BITS-1:0] dark_threshold;
        logic [TRIG_BITS-1:0]  trigger_ticks;
        logic [TOUT_BITS-1:0]  rise_timeout_ticks;
        logic [TOUT_BITS-1:0]  fall_timeout_ticks;
        logic [DIST_BITS-1:0]  near_limit_cm;
        logic [TICK_BITS-1:0]  hold_ticks;
        logic [TICK_BITS-1:0]  period_ticks;
    } cfg_t;

endpackage

// ===== rtl/dark_gated_sonar_presence_lamp.sv =====
// ----------------------------------------------------------------------------
// dark_gated_sonar_presence_lamp
// Night-only sonar presence detector driving a street lamp, one tick per beat.
// ----------------------------------------------------------------------------
// usage
//   - in channel: one beat per microsecond tick, carrying the echo pin level
//     and an optional light sample (latched when light_valid is set)
//   - out channel: one beat per input beat, in order: trigger pin drive,
//     lamp drive, last distance in cm and a done flag for a new distance
//   - cfg port: cfg_we writes cfg_data into the register chosen by cfg_index
//     at the clock edge; indexes above the list are ignored; write only idle
//   - result path: a taken beat waits in the input register, then the
//     sequencer step writes its result into the output register
//   - throughput: one beat per cycle while out_ready is high; the tick step is
//     a single pass of counter compares and one 16x11 multiply for the distance
//   - stall: while out_ready is low the output register holds its beat and
//     the input register still takes one more beat; after that in_ready drops
//   - reset: sequencer starts a new cycle with lamp off and distance zero,
//     registers return to their default settings, both stages empty
// ----------------------------------------------------------------------------
module dark_gated_sonar_presence_lamp
    import dgspl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t      cfg;
    out_item_t step_result;

    // input stage
    logic      in_valid_reg;
    in_item_t  in_data_reg;

    // output stage
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      advance;

    // the held beat moves into the sequencer when the output stage has room
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dgspl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dgspl_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload registers load without reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/dgspl_cfg.sv =====
// ----------------------------------------------------------------------------
// dgspl_cfg
// Configuration register file, written by index, reset to default settings.
// ----------------------------------------------------------------------------
module dgspl_cfg
    import dgspl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold     <= RST_DARK_THRESHOLD;
            cfg_reg.trigger_ticks      <= RST_TRIGGER_TICKS;
            cfg_reg.rise_timeout_ticks <= RST_RISE_TIMEOUT;
            cfg_reg.fall_timeout_ticks <= RST_FALL_TIMEOUT;
            cfg_reg.near_limit_cm      <= RST_NEAR_LIMIT;
            cfg_reg.hold_ticks         <= RST_HOLD_TICKS;
            cfg_reg.period_ticks       <= RST_PERIOD_TICKS;
        end
        else if (cfg_we)
        begin
            // wider data is truncated to the register width
            case (cfg_index)
                CFG_DARK_THRESHOLD: cfg_reg.dark_threshold     <= cfg_data[LIGHT_BITS-1:0];
                CFG_TRIGGER_TICKS:  cfg_reg.trigger_ticks      <= cfg_data[TRIG_BITS-1:0];
                CFG_RISE_TIMEOUT:   cfg_reg.rise_timeout_ticks <= cfg_data[TOUT_BITS-1:0];
                CFG_FALL_TIMEOUT:   cfg_reg.fall_timeout_ticks <= cfg_data[TOUT_BITS-1:0];
                CFG_NEAR_LIMIT:     cfg_reg.near_limit_cm      <= cfg_data[DIST_BITS-1:0];
                CFG_HOLD_TICKS:     cfg_reg.hold_ticks         <= cfg_data[TICK_BITS-1:0];
                CFG_PERIOD_TICKS:   cfg_reg.period_ticks       <= cfg_data[TICK_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dgspl_seq.sv =====
// ----------------------------------------------------------------------------
// dgspl_seq
// Ranging sequencer: phase state, tick counter, echo width and lamp state,
// advanced by one tick per beat, with the result of that tick.
// ----------------------------------------------------------------------------
module dgspl_seq
    import dgspl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    phase_t                phase_reg,  phase_next;
    logic [TICK_BITS-1:0]  tick_reg,   tick_next;
    logic [LIGHT_BITS-1:0] light_reg,  light_next;
    logic [WIDTH_BITS-1:0] width_reg,  width_next;
    logic [DIST_BITS-1:0]  dist_reg,   dist_next;
    logic                  lamp_reg,   lamp_next;

    logic [TICK_BITS:0]    tick_inc;
    logic [WIDTH_BITS-1:0] width_sat;
    logic                  finish;
    logic [WIDTH_BITS-1:0] fin_width;
    logic [PROD_BITS-1:0]  product;
    logic [DIST_BITS-1:0]  fin_dist;
    logic                  done;

    always_comb
    begin
        light_next = item.light_valid ? item.light_sample : light_reg;
        tick_inc   = {1'b0, tick_reg} + 1'b1;
        width_sat  = (width_reg == {WIDTH_BITS{1'b1}}) ? width_reg : width_reg + 1'b1;

        phase_next = phase_reg;
        tick_next  = tick_reg;
        width_next = width_reg;
        dist_next  = dist_reg;
        lamp_next  = lamp_reg;
        finish     = 1'b0;
        fin_width  = '0;

        case (phase_reg)
            PH_START:
            begin
                tick_next = '0;
                if (light_next > cfg.dark_threshold)
                begin
                    phase_next = PH_TRIG;
                end
                else
                begin
                    lamp_next  = 1'b0;
                    phase_next = PH_PERIOD;
                end
            end
            PH_TRIG:
            begin
                tick_next = tick_inc[TICK_BITS-1:0];
                if (tick_inc >= {{(TICK_BITS+1-TRIG_BITS){1'b0}}, cfg.trigger_ticks})
                begin
                    tick_next  = '0;
                    phase_next = PH_RISE;
                end
            end
            PH_RISE:
            begin
                if (item.echo_level)
                begin
                    tick_next  = '0;
                    width_next = '0;
                    phase_next = PH_FALL;
                end
                else
                begin
                    tick_next = tick_inc[TICK_BITS-1:0];
                    // no echo: width 0 ends the measurement
                    if (tick_inc >= {{(TICK_BITS+1-TOUT_BITS){1'b0}}, cfg.rise_timeout_ticks})
                    begin
                        finish = 1'b1;
                    end
                end
            end
            PH_FALL:
            begin
                if (!item.echo_level)
                begin
                    finish    = 1'b1;
                    fin_width = width_reg;
                end
                else
                begin
                    width_next = width_sat;
                    tick_next  = tick_inc[TICK_BITS-1:0];
                    if (tick_inc >= {{(TICK_BITS+1-TOUT_BITS){1'b0}}, cfg.fall_timeout_ticks})
                    begin
                        finish    = 1'b1;
                        fin_width = width_sat;
                    end
                end
            end
            PH_HOLD:
            begin
                tick_next = tick_inc[TICK_BITS-1:0];
                if (tick_inc >= {1'b0, cfg.hold_ticks})
                begin
                    tick_next  = '0;
                    phase_next = PH_PERIOD;
                end
            end
            PH_PERIOD:
            begin
                tick_next = tick_inc[TICK_BITS-1:0];
                if (tick_inc >= {1'b0, cfg.period_ticks})
                begin
                    tick_next  = '0;
                    phase_next = PH_START;
                end
            end
            default:
            begin
                tick_next  = '0;
                phase_next = PH_START;
            end
        endcase

        // width is at most 16 bits, so the distance never exceeds 1113
        product  = {{DIST_BITS{1'b0}}, fin_width} * PROD_BITS'(DIST_SCALE);
        fin_dist = product[DIST_SHIFT +: DIST_BITS];
        done     = finish;

        if (finish)
        begin
            width_next = fin_width;
            dist_next  = fin_dist;
            tick_next  = '0;
            if ((fin_dist != '0) && (fin_dist < cfg.near_limit_cm))
            begin
                lamp_next  = 1'b1;
                phase_next = PH_HOLD;
            end
            else
            begin
                lamp_next  = 1'b0;
                phase_next = PH_PERIOD;
            end
        end

        result.trigger_out   = (phase_next == PH_TRIG);
        result.lamp_on       = lamp_next;
        result.distance_cm   = dist_next;
        result.distance_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            tick_reg  <= '0;
            light_reg <= '0;
            width_reg <= '0;
            dist_reg  <= '0;
            lamp_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            light_reg <= light_next;
            width_reg <= width_next;
            dist_reg  <= dist_next;
            lamp_reg  <= lamp_next;
        end
    end

endmodule

// ===== sim/dark_gated_sonar_presence_lamp_tb.sv =====
// ----------------------------------------------------------------------------
// dark_gated_sonar_presence_lamp_tb
// Self-checking bench for the night-only sonar lamp controller. An opening
// table walks the threshold edge, zero-length trigger and waits, rise timeout,
// an echo cut by the fall timeout at the largest presence bound and the
// distance 0/1 edge.
// Random beats follow, shaped as trigger/echo sequences with some noise,
// under several register settings and idle patterns. Every result beat is
// compared with an in-bench model of the tick sequencer.
// ----------------------------------------------------------------------------
module dark_gated_sonar_presence_lamp_tb;
    import dgspl_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int RANGE_CEIL  = (1 << DIST_BITS) - 1;
    localparam int HOLD_OFF    = 80;
    // one index past the register list, the block must drop such a write
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct {
        in_item_t  beat;
        int        reps;
        bit        fixed;
        out_item_t want;
    } dir_row_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_item_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_item_t                out_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // idle knobs, in percent per cycle
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int rx_hold_left = 0;

    int errors       = 0;
    int result_count = 0;
    int stuck_cycles = 0;

    // lamp model state and its copy of the registers
    phase_t                lamp_phase;
    logic [TICK_BITS-1:0]  lamp_ticks;
    logic [LIGHT_BITS-1:0] light_held;
    logic [WIDTH_BITS-1:0] echo_count;
    logic [DIST_BITS-1:0]  range_cm;
    logic                  lamp_lit;
    cfg_t                  lamp_cfg;

    // echo sequence plan for the random beats
    int rise_wait_left = 0;
    int echo_high_left = 0;
    bit garble         = 1'b0;

    out_item_t lamp_beats_due[$];
    dir_row_t  opening[$];

    always #5 clk = ~clk;

    dark_gated_sonar_presence_lamp i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // lamp model
    // ------------------------------------------------------------------------
    function automatic void clear_lamp_model();
        lamp_cfg.dark_threshold     = RST_DARK_THRESHOLD;
        lamp_cfg.trigger_ticks      = RST_TRIGGER_TICKS;
        lamp_cfg.rise_timeout_ticks = RST_RISE_TIMEOUT;
        lamp_cfg.fall_timeout_ticks = RST_FALL_TIMEOUT;
        lamp_cfg.near_limit_cm      = RST_NEAR_LIMIT;
        lamp_cfg.hold_ticks         = RST_HOLD_TICKS;
        lamp_cfg.period_ticks       = RST_PERIOD_TICKS;
        lamp_phase = PH_START;
        lamp_ticks = '0;
        light_held = '0;
        echo_count = '0;
        range_cm   = '0;
        lamp_lit   = 1'b0;
    endfunction

    // register write as the block sees it: masked to the field, unknown index dropped
    function automatic void store_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] v);
        case (idx)
            CFG_DARK_THRESHOLD: lamp_cfg.dark_threshold     = v[LIGHT_BITS-1:0];
            CFG_TRIGGER_TICKS:  lamp_cfg.trigger_ticks      = v[TRIG_BITS-1:0];
            CFG_RISE_TIMEOUT:   lamp_cfg.rise_timeout_ticks = v[TOUT_BITS-1:0];
            CFG_FALL_TIMEOUT:   lamp_cfg.fall_timeout_ticks = v[TOUT_BITS-1:0];
            CFG_NEAR_LIMIT:     lamp_cfg.near_limit_cm      = v[DIST_BITS-1:0];
            CFG_HOLD_TICKS:     lamp_cfg.hold_ticks         = v[TICK_BITS-1:0];
            CFG_PERIOD_TICKS:   lamp_cfg.period_ticks       = v[TICK_BITS-1:0];
            default: ;
        endcase
    endfunction

    // end of a measurement: width to cm, then lamp decision
    function automatic void close_range();
        logic [31:0] prod;
        logic [31:0] cm;
        prod = 32'(echo_count) * 32'(DIST_SCALE);
        cm   = prod >> DIST_SHIFT;
        if (cm > RANGE_CEIL)
            cm = RANGE_CEIL;
        range_cm   = cm[DIST_BITS-1:0];
        lamp_ticks = '0;
        if (range_cm >= 1 && range_cm < lamp_cfg.near_limit_cm)
        begin
            lamp_lit   = 1'b1;
            lamp_phase = PH_HOLD;
        end
        else
        begin
            lamp_lit   = 1'b0;
            lamp_phase = PH_PERIOD;
        end
    endfunction

    // one tick of the sequencer, returns the result beat it causes
    function automatic out_item_t next_lamp_beat(input in_item_t d);
        out_item_t          r;
        logic [TICK_BITS:0] nxt;
        bit                 done;
        done = 1'b0;
        if (d.light_valid)
            light_held = d.light_sample;
        // count one wider so a wrap past the tick width still ends the wait
        nxt = {1'b0, lamp_ticks} + 1'b1;
        case (lamp_phase)
            PH_START:
            begin
                lamp_ticks = '0;
                if (light_held > lamp_cfg.dark_threshold)
                    lamp_phase = PH_TRIG;
                else
                begin
                    lamp_lit   = 1'b0;
                    lamp_phase = PH_PERIOD;
                end
            end
            PH_TRIG:
            begin
                lamp_ticks = nxt[TICK_BITS-1:0];
                if (nxt >= lamp_cfg.trigger_ticks)
                begin
                    lamp_ticks = '0;
                    lamp_phase = PH_RISE;
                end
            end
            PH_RISE:
            begin
                if (d.echo_level)
                begin
                    lamp_ticks = '0;
                    echo_count = '0;
                    lamp_phase = PH_FALL;
                end
                else
                begin
                    lamp_ticks = nxt[TICK_BITS-1:0];
                    if (nxt >= lamp_cfg.rise_timeout_ticks)
                    begin
                        echo_count = '0;
                        close_range();
                        done = 1'b1;
                    end
                end
            end
            PH_FALL:
            begin
                if (!d.echo_level)
                begin
                    close_range();
                    done = 1'b1;
                end
                else
                begin
                    if (echo_count != '1)
                        echo_count = echo_count + 1'b1;
                    lamp_ticks = nxt[TICK_BITS-1:0];
                    if (nxt >= lamp_cfg.fall_timeout_ticks)
                    begin
                        close_range();
                        done = 1'b1;
                    end
                end
            end
            PH_HOLD:
            begin
                lamp_ticks = nxt[TICK_BITS-1:0];
                if (nxt >= lamp_cfg.hold_ticks)
                begin
                    lamp_ticks = '0;
                    lamp_phase = PH_PERIOD;
                end
            end
            PH_PERIOD:
            begin
                lamp_ticks = nxt[TICK_BITS-1:0];
                if (nxt >= lamp_cfg.period_ticks)
                begin
                    lamp_ticks = '0;
                    lamp_phase = PH_START;
                end
            end
            default:
            begin
                lamp_ticks = '0;
                lamp_phase = PH_START;
            end
        endcase
        r.trigger_out   = (lamp_phase == PH_TRIG);
        r.lamp_on       = lamp_lit;
        r.distance_cm   = range_cm;
        r.distance_done = done;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic dir_row_t mk_row(input in_item_t beat, input int reps,
                                        input bit fixed, input out_item_t want);
        dir_row_t r;
        r.beat  = beat;
        r.reps  = reps;
        r.fixed = fixed;
        r.want  = want;
        return r;
    endfunction

    // random beat that mostly follows a trigger, a delayed echo and a set width
    function automatic in_item_t draw_beat(input int rise_span, input int width_span);
        in_item_t d;
        int       pick;
        d.light_valid = ($urandom_range(5) == 0);
        if ($urandom_range(3) != 0)
            d.light_sample = LIGHT_BITS'($urandom_range(4095, lamp_cfg.dark_threshold));
        else
            d.light_sample = LIGHT_BITS'($urandom_range(4095));
        case (lamp_phase)
            PH_RISE:
            begin
                if (garble)
                    d.echo_level = 1'($urandom_range(1));
                else if (rise_wait_left > 0)
                begin
                    rise_wait_left--;
                    d.echo_level = 1'b0;
                end
                else
                    d.echo_level = 1'b1;
            end
            PH_FALL:
            begin
                if (garble)
                    d.echo_level = 1'($urandom_range(1));
                else if (echo_high_left > 0)
                begin
                    echo_high_left--;
                    d.echo_level = 1'b1;
                end
                else
                    d.echo_level = 1'b0;
            end
            default:
            begin
                // echo is a don't-care here, so plan the next measurement
                d.echo_level   = 1'($urandom_range(1));
                garble         = ($urandom_range(99) < 12);
                rise_wait_left = $urandom_range(rise_span);
                pick           = $urandom_range(3);
                if (pick < 2)
                    echo_high_left = $urandom_range(70, 50);
                else if (pick == 2)
                    echo_high_left = $urandom_range(8);
                else
                    echo_high_left = $urandom_range(width_span);
            end
        endcase
        return d;
    endfunction

    // offer one beat, predicted at hand-off, and hold it until taken
    task automatic send_beat(input in_item_t d, input bit fixed, input out_item_t want);
        out_item_t guess;
        @(negedge clk);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        guess = next_lamp_beat(d);
        lamp_beats_due.push_back(fixed ? want : guess);
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering and wait until every predicted beat has come out
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lamp_beats_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        store_setting(idx, v);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(CFG_DARK_THRESHOLD, CFG_DATA_BITS'(c.dark_threshold));
        write_reg(CFG_TRIGGER_TICKS,  CFG_DATA_BITS'(c.trigger_ticks));
        write_reg(CFG_RISE_TIMEOUT,   CFG_DATA_BITS'(c.rise_timeout_ticks));
        write_reg(CFG_FALL_TIMEOUT,   CFG_DATA_BITS'(c.fall_timeout_ticks));
        write_reg(CFG_NEAR_LIMIT,     CFG_DATA_BITS'(c.near_limit_cm));
        write_reg(CFG_HOLD_TICKS,     CFG_DATA_BITS'(c.hold_ticks));
        write_reg(CFG_PERIOD_TICKS,   CFG_DATA_BITS'(c.period_ticks));
    endtask

    // random stretch; with squeeze set the receiver backs off and the sender pauses
    task automatic run_random(input int beats, input int rise_span,
                              input int width_span, input bit squeeze);
        in_item_t d;
        for (int i = 0; i < beats; i++)
        begin
            if (squeeze && i == 120)
                rx_hold_req = 1'b1;
            if (squeeze && i == 260)
                drain_results();
            d = draw_beat(rise_span, width_span);
            send_beat(d, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        if (errors < 100)
            $display("mismatch at result beat %0d: %s", result_count, what);
        errors++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // receiver: random stalls, plus a long hold-off counted here on request
    always @(negedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_left = HOLD_OFF;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // every taken result beat against the oldest prediction
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lamp_beats_due.size() == 0)
                flag_mismatch("result beat with nothing expected");
            else
            begin
                want = lamp_beats_due.pop_front();
                check_field("trigger_out", out_data.trigger_out, want.trigger_out);
                check_field("lamp_on", out_data.lamp_on, want.lamp_on);
                check_field("distance_cm", out_data.distance_cm, want.distance_cm);
                check_field("distance_done", out_data.distance_done, want.distance_done);
            end
            result_count++;
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("dark_gated_sonar_presence_lamp test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_lamp_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender idle chance 10 percent, receiver stall chance 74 percent
        tx_idle_pct  = 10;
        rx_stall_pct = 74;

        // opening setting: zero trigger/hold/period, short fall timeout, top near bound
        load_settings(cfg_t'{12'd3000, 8'd0, 16'd3, 16'd200, 11'd1114, 22'd0, 22'd0});
        write_reg(CFG_UNUSED_IDX, '1);

        // light level equal to the threshold is still daylight
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b1, 12'd3000}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b1, 12'd3001}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b0}));
        // stale sample one above the threshold starts a trigger
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd4095}, 1, 1'b1,
                                 out_item_t'{1'b1, 1'b0, 11'd0, 1'b0}));
        // zero-length trigger lasts one tick
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 2, 1'b0, '0));
        // echo never rises: timeout gives distance zero
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b1}));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b1, 12'd4095}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b1, 1'b0, 11'd0, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b0}));
        // echo cut by the fall timeout at width 200: 3 cm, lamp on under the top bound
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 1, 1'b0, '0));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 199, 1'b0, '0));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b1, 11'd3, 1'b1}));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b1, 11'd3, 1'b0}));
        // daylight sample forces the lamp off at the next cycle start
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b1, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b1, 11'd3, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd3, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b1, 12'd4095}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd3, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b1, 1'b0, 11'd3, 1'b0}));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd3, 1'b0}));
        // width 58 rounds down to zero cm, 59 gives one cm
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 59, 1'b0, '0));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b1}));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 3, 1'b0, '0));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 60, 1'b0, '0));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b1, 11'd1, 1'b1}));
        // echo drops right after rising: zero width, lamp off
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 4, 1'b0, '0));
        opening.push_back(mk_row(in_item_t'{1'b1, 1'b0, 12'd0}, 1, 1'b0, '0));
        opening.push_back(mk_row(in_item_t'{1'b0, 1'b0, 12'd0}, 1, 1'b1,
                                 out_item_t'{1'b0, 1'b0, 11'd0, 1'b1}));

        foreach (opening[r])
            for (int k = 0; k < opening[r].reps; k++)
                send_beat(opening[r].beat, opening[r].fixed && k == opening[r].reps - 1,
                          opening[r].want);
        drain_results();

        // mid setting, short waits
        load_settings(cfg_t'{12'd2000, 8'd3, 16'd20, 16'd150, 11'd3, 22'd5, 22'd4});
        run_random(360, 24, 170, 1'b0);
        drain_results();

        // lowest bounds; trigger written with all ones, masked to the top value
        load_settings(cfg_t'{12'd0, 8'd255, 16'd1, 16'd1, 11'd1, 22'd0, 22'd0});
        write_reg(CFG_TRIGGER_TICKS, '1);
        run_random(280, 2, 3, 1'b0);
        drain_results();

        // the other way round: sender idles 74 of 100, receiver 10
        tx_idle_pct  = 74;
        rx_stall_pct = 10;

        // never dark and the longest waits: block parks in its idle wait
        load_settings(cfg_t'{12'd4095, 8'd1, 16'd65535, 16'd65535, 11'd1114,
                             22'd4194303, 22'd4194303});
        run_random(100, 10, 10, 1'b0);
        drain_results();

        // shorter waits again, the running count is already past them
        load_settings(cfg_t'{12'd1500, 8'd2, 16'd40, 16'd400, 11'd7, 22'd20, 22'd10});
        run_random(360, 45, 420, 1'b0);
        drain_results();

        // no idling, with a long receiver hold-off and a full sender pause
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        load_settings(cfg_t'{12'd2500, 8'd1, 16'd10, 16'd200, 11'd4, 22'd3, 22'd2});
        run_random(300, 12, 220, 1'b1);

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("dark_gated_sonar_presence_lamp test passed");
        else
            $display("dark_gated_sonar_presence_lamp test failed");
        $finish;
    end

endmodule
